// ===== design/periodic_timer_bank_core_assert.svh =====
// ----------------------------------------------------------------------------
// Periodic timer bank assertion macros
// Shorthand for the concurrent checks used in the timer bank RTL.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_CORE_ASSERT_SVH
`define PERIODIC_TIMER_BANK_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define PTB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define PTB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ptb_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic timer bank package
// Request and result types, opcodes and the slot memory word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

  // Operation codes carried in a request.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  // Largest number of slots that a request can address.
  localparam int MAX_SLOTS = 16;

  // One request.
  typedef struct packed {
    logic        opcode;
    logic [3:0]  slot;
    logic [31:0] period;
    logic        one_shot;
  } req_t;

  // One fired-slot report.
  typedef struct packed {
    logic [3:0]  fired_slot;
    logic [31:0] tick_value;
    logic        last;
  } result_t;

  // Contents of one slot memory entry.
  typedef struct packed {
    logic [31:0] period;
    logic        one_shot;
    logic [31:0] expiry;
  } slot_word_t;

endpackage

`default_nettype wire

// ===== design/ptb_slot_ram.sv =====
// ----------------------------------------------------------------------------
// Timer slot memory
// Synchronous single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptb_slot_ram #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  wire logic               clk_i,
  input  wire logic               wr_en_i,
  input  wire logic [AddrW-1:0]   wr_addr_i,
  input  wire ptb_pkg::slot_word_t wr_data_i,
  input  wire logic               rd_en_i,
  input  wire logic [AddrW-1:0]   rd_addr_i,
  output      ptb_pkg::slot_word_t rd_data_o
);

  ptb_pkg::slot_word_t mem [Depth];
  ptb_pkg::slot_word_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== design/periodic_timer_bank_core.sv =====
// ----------------------------------------------------------------------------
// Periodic timer bank core
// Bank of timer slots driven by a wrapping 32-bit tick counter. Slot periods
// and expiries live in a synchronous memory that a tick scans slot by slot.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                Payload
//   request   start, busy              req_i    (ptb_pkg::req_t)
//   result    result_valid_o strobe    result_o (ptb_pkg::result_t)
//
// An arm request is handled without raising busy; busy stays low.
// A tick request scans S slots, S being NUM_TIMERS capped at 16, with one
// memory read per slot through the single read port, then a flush state.
// Each report is held back until the next expiring slot is found or the scan
// ends, so the final report (marked last) appears in the cycle in which busy
// drops again.
// Reset clears the tick counter and all active flags; no memory clearing.
// Results cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_bank_core #(
  parameter int NUM_TIMERS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output      logic             busy,
  input  wire ptb_pkg::req_t    req_i,
  output      logic             result_valid_o,
  output      ptb_pkg::result_t result_o
);

  localparam int Slots = (NUM_TIMERS < ptb_pkg::MAX_SLOTS) ? NUM_TIMERS : ptb_pkg::MAX_SLOTS;
  localparam int AddrW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(Slots - 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFlush
  } state_e;

  state_e              state_q;
  logic [31:0]         tick_q;
  logic [Slots-1:0]    active_q;
  logic [AddrW-1:0]    chk_idx_q;
  logic                pend_v_q;
  logic [AddrW-1:0]    pend_slot_q;
  logic                result_valid_q;
  ptb_pkg::result_t    result_q;

  logic                accept;
  logic                tick_go;
  logic                arm_ok;
  logic                fire;
  logic                rd_en;
  logic [AddrW-1:0]    rd_addr;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  ptb_pkg::slot_word_t wr_data;
  ptb_pkg::slot_word_t rd_data;

  // Request decode.
  assign accept  = start && !busy;
  assign tick_go = accept && (req_i.opcode == ptb_pkg::OP_TICK);
  assign arm_ok  = accept && (req_i.opcode == ptb_pkg::OP_ARM)
                   && ({1'b0, req_i.slot} < 5'(Slots));

  // Read address: slot 0 when a tick is taken, then one slot ahead of the check.
  assign rd_en   = tick_go || ((state_q == StScan) && (chk_idx_q != LastIdx));
  assign rd_addr = (state_q == StScan) ? chk_idx_q + AddrW'(1) : '0;

  // Expiry check on the entry read in the previous cycle.
  assign fire = (state_q == StScan) && active_q[chk_idx_q] && (rd_data.expiry == tick_q);

  // Write port: arm from idle, or advance a periodic slot that fired.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = chk_idx_q;
    wr_data = rd_data;
    if (arm_ok) begin
      wr_en            = 1'b1;
      wr_addr          = req_i.slot[AddrW-1:0];
      wr_data.period   = req_i.period;
      wr_data.one_shot = req_i.one_shot;
      wr_data.expiry   = tick_q + req_i.period;
    end else if (fire && !rd_data.one_shot) begin
      wr_en          = 1'b1;
      wr_data.expiry = rd_data.expiry + rd_data.period;
    end
  end

  ptb_slot_ram #(
    .Depth (Slots),
    .AddrW (AddrW)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Sequencer. A fired slot is held back one report so that the final one
  // can be marked last when the scan ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      tick_q         <= '0;
      active_q       <= '0;
      chk_idx_q      <= '0;
      pend_v_q       <= 1'b0;
      pend_slot_q    <= '0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          result_valid_q <= 1'b0;
          if (tick_go) begin
            tick_q    <= tick_q + 32'd1;
            chk_idx_q <= '0;
            pend_v_q  <= 1'b0;
            state_q   <= StScan;
          end
          if (arm_ok) begin
            active_q[req_i.slot[AddrW-1:0]] <= 1'b1;
          end
        end
        StScan: begin
          chk_idx_q      <= chk_idx_q + AddrW'(1);
          result_valid_q <= fire && pend_v_q;
          if (fire) begin
            if (pend_v_q) begin
              result_q.fired_slot <= 4'(pend_slot_q);
              result_q.tick_value <= tick_q;
              result_q.last       <= 1'b0;
            end
            pend_v_q    <= 1'b1;
            pend_slot_q <= chk_idx_q;
            if (rd_data.one_shot) begin
              active_q[chk_idx_q] <= 1'b0;
            end
          end
          if (chk_idx_q == LastIdx) begin
            state_q <= StFlush;
          end
        end
        StFlush: begin
          result_valid_q <= pend_v_q;
          if (pend_v_q) begin
            result_q.fired_slot <= 4'(pend_slot_q);
            result_q.tick_value <= tick_q;
            result_q.last       <= 1'b1;
          end
          pend_v_q <= 1'b0;
          state_q  <= StIdle;
        end
        default: begin
          result_valid_q <= 1'b0;
          state_q        <= StIdle;
        end
      endcase
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // Checks on the sequencing.
  `include "periodic_timer_bank_core_assert.svh"

  `PTB_ASSERT(a_last_ends_scan, !(result_valid_o && result_o.last) || !busy, "last while busy")
  `PTB_ASSERT(a_report_from_scan, !result_valid_o || $past(busy), "report without a scan")
  `PTB_ASSERT_NEXT(a_tick_busy, tick_go, busy, "tick request did not start a scan")
  `PTB_ASSERT_NEXT(a_arm_quick, accept && !tick_go, !busy, "arm request left the block busy")
  `PTB_ASSERT(a_one_write, !(arm_ok && fire), "arm and expiry update collide")

endmodule

`default_nettype wire
